// ===== hw/rtl/dcc_pkg.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// dcc_pkg
// Shared types and codes for the MSI directory coherence controller.
// -----------------------------------------------------------------------------
package dcc_pkg;

	localparam int CORES_DEF = 4;
	localparam int LINES_DEF = 4;
	localparam int DATA_W    = 32;
	localparam int CQ_DEPTH  = 2;
	localparam int OQ_DEPTH  = 2;

	// line / directory states
	localparam logic [1:0] ST_U = 2'd0;
	localparam logic [1:0] ST_S = 2'd1;
	localparam logic [1:0] ST_M = 2'd2;

	// message kinds
	localparam logic [1:0] MK_HIT   = 2'd0;
	localparam logic [1:0] MK_INV   = 2'd1;
	localparam logic [1:0] MK_DOWN  = 2'd2;
	localparam logic [1:0] MK_GRANT = 2'd3;

	// access class decided by the front end
	typedef enum logic [1:0] {
		CK_HIT_RD  = 2'd0,
		CK_HIT_WR  = 2'd1,
		CK_RD_MISS = 2'd2,
		CK_WR_MISS = 2'd3
	} cmd_kind_t;

	typedef struct packed {
		logic [1:0]        kind;
		logic [1:0]        tgt;
		logic [DATA_W-1:0] value;
		logic [1:0]        gst;
		logic              last;
	} msg_t;

endpackage
`default_nettype wire

// ===== hw/rtl/directory_coherence_controller.sv =====
// Path: an access is registered, classified and queued as a command; the back end
// emits its messages, reading line data first for read hits and each INV or DOWN.
// Flow: the front end holds one access at a time and is full until it is queued;
// the back end runs one command at a time and stalls while the output queue is full.
// Reset: asynchronous; directory valid bits and both queues clear at once,
// no clearing pass, the block accepts accesses right after reset.
`default_nettype none
// -----------------------------------------------------------------------------
// directory_coherence_controller
// MSI directory with per-core private line stores: front end classifies
// accesses and updates the directory, back end emits coherence messages.
// -----------------------------------------------------------------------------
module directory_coherence_controller #(
	parameter int CORES = dcc_pkg::CORES_DEF,
	parameter int LINES = dcc_pkg::LINES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic                              func,
	input  wire logic [1:0]                        core_id,
	input  wire logic [1:0]                        addr,
	input  wire logic signed [dcc_pkg::DATA_W-1:0] write_value,
	input  wire logic signed [dcc_pkg::DATA_W-1:0] memory_value,
	output logic                                   empty,
	input  wire logic                              pop,
	output logic [1:0]                             msg_kind,
	output logic [1:0]                             target_core,
	output logic signed [dcc_pkg::DATA_W-1:0]      value,
	output logic [1:0]                             granted_state,
	output logic                                   last
);

	localparam int CW    = $clog2(CORES);
	localparam int AW    = (LINES > 1) ? $clog2(LINES) : 1;
	localparam int CMD_W = 2 + CW + AW + 2 * dcc_pkg::DATA_W + CW + CORES + 3;
	localparam int MSG_W = $bits(dcc_pkg::msg_t);

	logic             cq_push;
	logic             cq_full;
	logic [CMD_W-1:0] cq_wdata;
	logic             cq_pop;
	logic             cq_empty;
	logic [CMD_W-1:0] cq_rdata;
	logic             oq_push;
	logic             oq_full;
	dcc_pkg::msg_t    oq_wdata;
	dcc_pkg::msg_t    oq_rdata;

	dcc_front #(
		.CORES(CORES),
		.LINES(LINES),
		.CW   (CW),
		.AW   (AW),
		.CMD_W(CMD_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.func        (func),
		.core_id     (core_id),
		.addr        (addr),
		.write_value (write_value),
		.memory_value(memory_value),
		.cq_full     (cq_full),
		.cq_push     (cq_push),
		.cq_data     (cq_wdata)
	);

	dcc_fifo #(
		.W    (CMD_W),
		.DEPTH(dcc_pkg::CQ_DEPTH)
	) u_cmd_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (cq_push),
		.wdata (cq_wdata),
		.full  (cq_full),
		.pop   (cq_pop),
		.rdata (cq_rdata),
		.empty (cq_empty)
	);

	dcc_back #(
		.CORES(CORES),
		.LINES(LINES),
		.CW   (CW),
		.AW   (AW),
		.CMD_W(CMD_W)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cq_empty(cq_empty),
		.cq_pop  (cq_pop),
		.cq_data (cq_rdata),
		.oq_full (oq_full),
		.oq_push (oq_push),
		.oq_data (oq_wdata)
	);

	dcc_fifo #(
		.W    (MSG_W),
		.DEPTH(dcc_pkg::OQ_DEPTH)
	) u_msg_q (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (oq_push),
		.wdata (oq_wdata),
		.full  (oq_full),
		.pop   (pop),
		.rdata (oq_rdata),
		.empty (empty)
	);

	assign msg_kind      = oq_rdata.kind;
	assign target_core   = oq_rdata.tgt;
	assign value         = oq_rdata.value;
	assign granted_state = oq_rdata.gst;
	assign last          = oq_rdata.last;

endmodule
`default_nettype wire

// ===== hw/rtl/dcc_ram.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// dcc_ram
// Generic single-write, single-read RAM with registered read data.
// -----------------------------------------------------------------------------
module dcc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ===== hw/rtl/dcc_fifo.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// dcc_fifo
// Small register queue with push/full and pop/empty sides.
// -----------------------------------------------------------------------------
module dcc_fifo #(
	parameter int W     = 8,
	parameter int DEPTH = 2
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire logic [W-1:0] wdata,
	output logic              full,
	input  wire logic         pop,
	output logic [W-1:0]      rdata,
	output logic              empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [W-1:0]  mem_q [DEPTH];
	logic [PW-1:0] wptr_q;
	logic [PW-1:0] rptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wptr_q <= (wptr_q == PW'(DEPTH - 1)) ? '0 : wptr_q + PW'(1);
			end
			if (do_pop) begin
				rptr_q <= (rptr_q == PW'(DEPTH - 1)) ? '0 : rptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CW'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/dcc_front.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// dcc_front
// Accepts accesses, looks up and updates the directory, classifies each
// access and queues a command for the back end.
// -----------------------------------------------------------------------------
module dcc_front #(
	parameter int CORES = dcc_pkg::CORES_DEF,
	parameter int LINES = dcc_pkg::LINES_DEF,
	parameter int CW    = $clog2(CORES),
	parameter int AW    = (LINES > 1) ? $clog2(LINES) : 1,
	parameter int CMD_W = 2 + CW + AW + 2 * dcc_pkg::DATA_W + CW + CORES + 3
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              push,
	output logic                                   full,
	input  wire logic                              func,
	input  wire logic [1:0]                        core_id,
	input  wire logic [1:0]                        addr,
	input  wire logic signed [dcc_pkg::DATA_W-1:0] write_value,
	input  wire logic signed [dcc_pkg::DATA_W-1:0] memory_value,
	input  wire logic                              cq_full,
	output logic                                   cq_push,
	output logic [CMD_W-1:0]                       cq_data
);

	localparam int DW = 2 + CW + CORES;

	typedef struct packed {
		dcc_pkg::cmd_kind_t          kind;
		logic [CW-1:0]               req;
		logic [AW-1:0]               a;
		logic [dcc_pkg::DATA_W-1:0]  wval;
		logic [dcc_pkg::DATA_W-1:0]  mval;
		logic [CW-1:0]               own;
		logic [CORES-1:0]            mask;
		logic [1:0]                  hit_st;
		logic                        down;
	} cmd_t;

	typedef enum logic [1:0] {
		F_IDLE  = 2'b01,
		F_CLASS = 2'b10
	} fstate_t;

	fstate_t                    state_q;
	logic                       wr_q;
	logic [CW-1:0]              req_q;
	logic [AW-1:0]              a_q;
	logic [dcc_pkg::DATA_W-1:0] wval_q;
	logic [dcc_pkg::DATA_W-1:0] mval_q;
	logic [LINES-1:0]           dvalid_q;

	logic [4:0]       core_t;
	logic [8:0]       addr_t;
	logic [CW-1:0]    req_in;
	logic [AW-1:0]    a_in;
	logic             accept;
	logic [DW-1:0]    dir_rdata;
	logic [DW-1:0]    entry;
	logic [DW-1:0]    new_entry;
	logic [1:0]       st;
	logic [CW-1:0]    own;
	logic [CORES-1:0] shr;
	logic [CORES-1:0] req_bit;
	logic [CORES-1:0] own_bit;
	logic             line_ok;
	logic             dir_we;
	cmd_t             cmd;

	assign full   = (state_q == F_CLASS);
	assign accept = push && (state_q == F_IDLE);

	// fold the incoming core and line indexes into range
	always_comb begin
		core_t = {3'b000, core_id};
		for (int i = 0; i < 2; i++) begin
			if (core_t >= 5'(CORES)) begin
				core_t = core_t - 5'(CORES);
			end
		end
		addr_t = {7'b0000000, addr};
		for (int i = 0; i < 3; i++) begin
			if (addr_t >= 9'(LINES)) begin
				addr_t = addr_t - 9'(LINES);
			end
		end
		req_in = core_t[CW-1:0];
		a_in   = addr_t[AW-1:0];
	end

	dcc_ram #(
		.WIDTH(DW),
		.DEPTH(LINES)
	) u_dir (
		.clk  (clk),
		.we   (dir_we),
		.waddr(a_q),
		.wdata(new_entry),
		.re   (accept),
		.raddr(a_in),
		.rdata(dir_rdata)
	);

	always_comb begin
		entry   = dvalid_q[a_q] ? dir_rdata : '0;
		st      = entry[DW-1 -: 2];
		own     = entry[CORES +: CW];
		shr     = entry[CORES-1:0];
		req_bit = CORES'(1) << req_q;
		own_bit = CORES'(1) << own;
		line_ok = ((st == dcc_pkg::ST_S) && shr[req_q]) ||
		          ((st == dcc_pkg::ST_M) && (own == req_q));

		cmd        = '0;
		cmd.req    = req_q;
		cmd.a      = a_q;
		cmd.wval   = wval_q;
		cmd.mval   = mval_q;
		cmd.own    = own;
		cmd.hit_st = (st == dcc_pkg::ST_M) ? dcc_pkg::ST_M : dcc_pkg::ST_S;
		new_entry  = entry;

		if (!wr_q && line_ok) begin
			cmd.kind = dcc_pkg::CK_HIT_RD;
		end else if (wr_q && line_ok && (st == dcc_pkg::ST_M)) begin
			cmd.kind = dcc_pkg::CK_HIT_WR;
		end else if (!wr_q) begin
			cmd.kind  = dcc_pkg::CK_RD_MISS;
			cmd.down  = (st == dcc_pkg::ST_M);
			new_entry = {dcc_pkg::ST_S, CW'(0),
			             ((st == dcc_pkg::ST_M) ? own_bit : shr) | req_bit};
		end else begin
			cmd.kind = dcc_pkg::CK_WR_MISS;
			if (st == dcc_pkg::ST_S) begin
				cmd.mask = shr & ~req_bit;
			end else if (st == dcc_pkg::ST_M) begin
				cmd.mask = own_bit;
			end
			new_entry = {dcc_pkg::ST_M, req_q, CORES'(0)};
		end
	end

	assign cq_push = (state_q == F_CLASS) && !cq_full;
	assign dir_we  = cq_push;
	assign cq_data = cmd;

	always_ff @(posedge clk) begin
		if (accept) begin
			wr_q   <= func;
			req_q  <= req_in;
			a_q    <= a_in;
			wval_q <= write_value;
			mval_q <= memory_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= F_IDLE;
			dvalid_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (accept) begin
						state_q <= F_CLASS;
					end
				end
				F_CLASS: begin
					// hold until the command queue takes the transfer
					if (cq_push) begin
						dvalid_q[a_q] <= 1'b1;
						state_q       <= F_IDLE;
					end
				end
				default: begin
					state_q <= F_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/dcc_back.sv =====
`default_nettype none
// -----------------------------------------------------------------------------
// dcc_back
// Executes queued commands against the private line stores and emits
// the hit, invalidate, downgrade and grant messages in order.
// -----------------------------------------------------------------------------
module dcc_back #(
	parameter int CORES = dcc_pkg::CORES_DEF,
	parameter int LINES = dcc_pkg::LINES_DEF,
	parameter int CW    = $clog2(CORES),
	parameter int AW    = (LINES > 1) ? $clog2(LINES) : 1,
	parameter int CMD_W = 2 + CW + AW + 2 * dcc_pkg::DATA_W + CW + CORES + 3
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cq_empty,
	output logic                    cq_pop,
	input  wire logic [CMD_W-1:0]   cq_data,
	input  wire logic               oq_full,
	output logic                    oq_push,
	output dcc_pkg::msg_t           oq_data
);

	localparam int LD = CORES * LINES;
	localparam int LW = $clog2(LD);

	typedef struct packed {
		dcc_pkg::cmd_kind_t          kind;
		logic [CW-1:0]               req;
		logic [AW-1:0]               a;
		logic [dcc_pkg::DATA_W-1:0]  wval;
		logic [dcc_pkg::DATA_W-1:0]  mval;
		logic [CW-1:0]               own;
		logic [CORES-1:0]            mask;
		logic [1:0]                  hit_st;
		logic                        down;
	} cmd_t;

	typedef enum logic [2:0] {
		B_IDLE = 3'b001,
		B_NEXT = 3'b010,
		B_EMIT = 3'b100
	} bstate_t;

	function automatic logic [LW-1:0] line_addr(input logic [CW-1:0] c,
	                                             input logic [AW-1:0] a);
		line_addr = LW'(LW'(c) * LW'(LINES) + LW'(a));
	endfunction

	function automatic logic [1:0] tgt2(input logic [CW-1:0] c);
		logic [CW+1:0] ext;
		ext  = {2'b00, c};
		tgt2 = ext[1:0];
	endfunction

	bstate_t                    state_q, state_d;
	cmd_t                       cmd_q, cmd_in;
	logic [CORES-1:0]           mask_q, mask_d;
	logic [dcc_pkg::DATA_W-1:0] data_q, data_d;
	logic                       down_q, down_d;
	logic [1:0]                 pkind_q, pkind_d;
	logic [CW-1:0]              ptgt_q, ptgt_d;
	logic [1:0]                 pgst_q, pgst_d;
	logic                       plast_q, plast_d;

	logic                       ram_we;
	logic [LW-1:0]              ram_waddr;
	logic [dcc_pkg::DATA_W-1:0] ram_wdata;
	logic                       ram_re;
	logic [LW-1:0]              ram_raddr;
	logic [dcc_pkg::DATA_W-1:0] ram_rdata;
	logic [CW-1:0]              low_c;

	assign cmd_in = cq_data;

	dcc_ram #(
		.WIDTH(dcc_pkg::DATA_W),
		.DEPTH(LD)
	) u_lines (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// lowest pending invalidation target
	always_comb begin
		low_c = '0;
		for (int i = CORES - 1; i >= 0; i--) begin
			if (mask_q[i]) begin
				low_c = CW'(i);
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		mask_d    = mask_q;
		data_d    = data_q;
		down_d    = down_q;
		pkind_d   = pkind_q;
		ptgt_d    = ptgt_q;
		pgst_d    = pgst_q;
		plast_d   = plast_q;
		cq_pop    = 1'b0;
		oq_push   = 1'b0;
		oq_data   = '0;
		ram_we    = 1'b0;
		ram_waddr = line_addr(cmd_q.req, cmd_q.a);
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = line_addr(cmd_q.req, cmd_q.a);

		case (state_q)
			B_IDLE: begin
				if (!cq_empty) begin
					cq_pop  = 1'b1;
					mask_d  = cmd_in.mask;
					data_d  = cmd_in.mval;
					down_d  = cmd_in.down;
					state_d = B_NEXT;
				end
			end
			B_NEXT: begin
				case (cmd_q.kind)
					dcc_pkg::CK_HIT_RD: begin
						ram_re  = 1'b1;
						pkind_d = dcc_pkg::MK_HIT;
						ptgt_d  = cmd_q.req;
						pgst_d  = cmd_q.hit_st;
						plast_d = 1'b1;
						state_d = B_EMIT;
					end
					dcc_pkg::CK_HIT_WR: begin
						if (!oq_full) begin
							ram_we    = 1'b1;
							ram_wdata = cmd_q.wval;
							oq_push   = 1'b1;
							oq_data   = '{dcc_pkg::MK_HIT, tgt2(cmd_q.req), cmd_q.wval,
							              dcc_pkg::ST_M, 1'b1};
							state_d   = B_IDLE;
						end
					end
					dcc_pkg::CK_RD_MISS: begin
						if (down_q) begin
							// fetch the owner's dirty copy to forward
							ram_re    = 1'b1;
							ram_raddr = line_addr(cmd_q.own, cmd_q.a);
							down_d    = 1'b0;
							pkind_d   = dcc_pkg::MK_DOWN;
							ptgt_d    = cmd_q.own;
							pgst_d    = dcc_pkg::ST_S;
							plast_d   = 1'b0;
							state_d   = B_EMIT;
						end else if (!oq_full) begin
							ram_we    = 1'b1;
							ram_wdata = data_q;
							oq_push   = 1'b1;
							oq_data   = '{dcc_pkg::MK_GRANT, tgt2(cmd_q.req), data_q,
							              dcc_pkg::ST_S, 1'b1};
							state_d   = B_IDLE;
						end
					end
					dcc_pkg::CK_WR_MISS: begin
						if (mask_q != '0) begin
							ram_re    = 1'b1;
							ram_raddr = line_addr(low_c, cmd_q.a);
							mask_d    = mask_q & ~(CORES'(1) << low_c);
							pkind_d   = dcc_pkg::MK_INV;
							ptgt_d    = low_c;
							pgst_d    = dcc_pkg::ST_U;
							plast_d   = 1'b0;
							state_d   = B_EMIT;
						end else if (!oq_full) begin
							ram_we    = 1'b1;
							ram_wdata = cmd_q.wval;
							oq_push   = 1'b1;
							oq_data   = '{dcc_pkg::MK_GRANT, tgt2(cmd_q.req), cmd_q.wval,
							              dcc_pkg::ST_M, 1'b1};
							state_d   = B_IDLE;
						end
					end
					default: begin
						state_d = B_IDLE;
					end
				endcase
			end
			B_EMIT: begin
				// read data holds while the output queue is full
				if (!oq_full) begin
					oq_push = 1'b1;
					oq_data = '{pkind_q, tgt2(ptgt_q), ram_rdata, pgst_q, plast_q};
					data_d  = ram_rdata;
					state_d = plast_q ? B_IDLE : B_NEXT;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cq_pop) begin
			cmd_q <= cmd_in;
		end
		mask_q  <= mask_d;
		data_q  <= data_d;
		down_q  <= down_d;
		pkind_q <= pkind_d;
		ptgt_q  <= ptgt_d;
		pgst_q  <= pgst_d;
		plast_q <= plast_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire
